### hdl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int IDX_W         = 9;   // handle index and count ports
  localparam int GEN_W         = 16;  // handle generation
  localparam int POS_W         = 8;   // probe position

  localparam logic [GEN_W-1:0] GEN_MAX   = 16'hFFFF;
  localparam logic [GEN_W-1:0] GEN_FIRST = 16'd1;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_CHECK   = 2'd2,
    MODE_PROBE   = 2'd3
  } gsa_mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } gsa_state_e;

endpackage

### hdl/gsa_slot_ram.sv
// ----------------------------------------------------------------------------
// gsa_slot_ram
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gsa_slot_ram #(
  parameter int DEPTH = gsa_pkg::MAX_SLOTS_DEF,
  parameter int DW    = 1 + gsa_pkg::GEN_W + 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/gsa_core.sv
// ----------------------------------------------------------------------------
// gsa_core
// Command sequencer: issues the slot read, then checks and updates the entry,
// the free list head and the counters, and registers the result word.
// ----------------------------------------------------------------------------
module gsa_core #(
  parameter int MAX_SLOTS = gsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              mode_i,
  input  logic [gsa_pkg::IDX_W-1:0]               handle_index_i,
  input  logic [gsa_pkg::GEN_W-1:0]               handle_generation_i,
  input  logic [gsa_pkg::POS_W-1:0]               slot_position_i,
  input  logic                                    definition_ok_i,
  output logic                                    done_o,
  output logic                                    ok_o,
  output logic [gsa_pkg::IDX_W-1:0]               out_index_o,
  output logic [gsa_pkg::GEN_W-1:0]               out_generation_o,
  output logic [gsa_pkg::IDX_W-1:0]               live_count_o,
  output logic [gsa_pkg::IDX_W-1:0]               opened_slots_o,
  // slot table port
  output logic                                    ram_we_o,
  output logic [$clog2(MAX_SLOTS)-1:0]            ram_waddr_o,
  output logic [gsa_pkg::GEN_W+$clog2(MAX_SLOTS+1):0] ram_wdata_o,
  output logic                                    ram_re_o,
  output logic [$clog2(MAX_SLOTS)-1:0]            ram_raddr_o,
  input  logic [gsa_pkg::GEN_W+$clog2(MAX_SLOTS+1):0] ram_rdata_i
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int XW = (CW > gsa_pkg::IDX_W) ? CW : gsa_pkg::IDX_W;
  localparam int GW = gsa_pkg::GEN_W;
  localparam int IW = gsa_pkg::IDX_W;
  localparam logic [XW-1:0] SLOTS_X = XW'(MAX_SLOTS);

  gsa_pkg::gsa_state_e state_q, state_d;
  gsa_pkg::gsa_mode_e  mode_q;

  logic [IW-1:0]               hidx_q;
  logic [GW-1:0]               hgen_q;
  logic [gsa_pkg::POS_W-1:0]   pos_q;
  logic                        defok_q;

  logic [CW-1:0] head_q, head_d;
  logic [CW-1:0] open_q, open_d;
  logic [CW-1:0] live_q, live_d;

  logic          done_q, done_d;
  logic          ok_q, ok_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic [GW-1:0] rgen_q, rgen_d;

  logic          accept;
  logic          exec;
  logic          e_busy;
  logic [GW-1:0] e_gen;
  logic [CW-1:0] e_next;
  logic          hit;
  logic          probe_hit;
  logic [XW-1:0] hidx_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] open_x;

  assign accept = start && !busy;
  assign {e_busy, e_gen, e_next} = ram_rdata_i;

  // ---- state machine ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsa_pkg::ST_IDLE: if (start) state_d = gsa_pkg::ST_EXEC;
      gsa_pkg::ST_EXEC: state_d = gsa_pkg::ST_IDLE;
      default:          state_d = gsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state_q)
      gsa_pkg::ST_IDLE: busy = 1'b0;
      gsa_pkg::ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  // ---- read address at accept ----
  always_comb begin
    ram_re_o    = accept;
    ram_raddr_o = '0;
    unique case (gsa_pkg::gsa_mode_e'(mode_i))
      gsa_pkg::MODE_ALLOC:   ram_raddr_o = AW'(head_q - 1'b1);
      gsa_pkg::MODE_RELEASE,
      gsa_pkg::MODE_CHECK:   ram_raddr_o = AW'(handle_index_i - 1'b1);
      gsa_pkg::MODE_PROBE:   ram_raddr_o = AW'(slot_position_i);
      default:               ram_raddr_o = '0;
    endcase
  end

  // ---- handle checks on the read entry ----
  assign hidx_x = XW'(hidx_q);
  assign pos_x  = XW'(pos_q);
  assign open_x = XW'(open_q);

  assign hit = (hidx_q != '0) && (hidx_x <= open_x) && (hidx_x <= SLOTS_X) &&
               e_busy && (e_gen == hgen_q);
  assign probe_hit = (pos_x < open_x) && (pos_x < SLOTS_X) && e_busy;

  // ---- execute: modify, write back, form result ----
  always_comb begin
    head_d      = head_q;
    open_d      = open_q;
    live_d      = live_q;
    done_d      = exec;
    ok_d        = ok_q;
    ridx_d      = ridx_q;
    rgen_d      = rgen_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(hidx_q - 1'b1);
    ram_wdata_o = '0;
    if (exec) begin
      ok_d   = 1'b0;
      ridx_d = '0;
      rgen_d = '0;
      unique case (mode_q)
        gsa_pkg::MODE_ALLOC: begin
          if (defok_q) begin
            if (head_q != '0) begin
              // pop the free list
              ram_we_o    = 1'b1;
              ram_waddr_o = AW'(head_q - 1'b1);
              ram_wdata_o = {1'b1, e_gen, CW'(0)};
              head_d      = e_next;
              live_d      = CW'(live_q + 1'b1);
              ok_d        = 1'b1;
              ridx_d      = IW'(head_q);
              rgen_d      = e_gen;
            end else if (open_x < SLOTS_X) begin
              // open a fresh slot
              ram_we_o    = 1'b1;
              ram_waddr_o = AW'(open_q);
              ram_wdata_o = {1'b1, gsa_pkg::GEN_FIRST, CW'(0)};
              open_d      = CW'(open_q + 1'b1);
              live_d      = CW'(live_q + 1'b1);
              ok_d        = 1'b1;
              ridx_d      = IW'(open_q + 1'b1);
              rgen_d      = gsa_pkg::GEN_FIRST;
            end
          end
        end
        gsa_pkg::MODE_RELEASE: begin
          if (hit) begin
            ram_we_o = 1'b1;
            live_d   = CW'(live_q - 1'b1);
            ok_d     = 1'b1;
            if (e_gen != gsa_pkg::GEN_MAX) begin
              ram_wdata_o = {1'b0, GW'(e_gen + 1'b1), head_q};
              head_d      = CW'(hidx_q);
            end else begin
              // retired: never handed out again
              ram_wdata_o = '0;
            end
          end
        end
        gsa_pkg::MODE_CHECK: ok_d = hit;
        gsa_pkg::MODE_PROBE: begin
          if (probe_hit) begin
            ok_d   = 1'b1;
            ridx_d = IW'({1'b0, pos_q} + 1'b1);
            rgen_d = e_gen;
          end
        end
        default: ok_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsa_pkg::ST_IDLE;
      head_q  <= '0;
      open_q  <= '0;
      live_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      open_q  <= open_d;
      live_q  <= live_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= gsa_pkg::gsa_mode_e'(mode_i);
      hidx_q  <= handle_index_i;
      hgen_q  <= handle_generation_i;
      pos_q   <= slot_position_i;
      defok_q <= definition_ok_i;
    end
    ok_q   <= ok_d;
    ridx_q <= ridx_d;
    rgen_q <= rgen_d;
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign out_index_o      = ridx_q;
  assign out_generation_o = rgen_q;
  assign live_count_o     = IW'(live_q);
  assign opened_slots_o   = IW'(open_q);

endmodule

### hdl/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Generational handle allocator with a LIFO free list kept in a slot table.
//
//  port group          dir  timing
//  start / busy        in   word taken at clk edge with start=1, busy=0
//  command fields      in   mode, handle, position, definition_ok
//  done_o              out  one-cycle strobe, receiver cannot stall
//  result fields       out  ok, handle, live and opened counts
//
// For each word, the slot table read (registered read data) is issued on accept,
// and the entry is checked and written back in the next cycle.
// busy is high in that cycle; the result strobes in the cycle after it,
// while the next word may already be taken.
// Reset clears the free list head and counters; the table needs no clearing.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
  parameter int MAX_SLOTS = gsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode_i,
  input  logic [gsa_pkg::IDX_W-1:0] handle_index_i,
  input  logic [gsa_pkg::GEN_W-1:0] handle_generation_i,
  input  logic [gsa_pkg::POS_W-1:0] slot_position_i,
  input  logic                      definition_ok_i,
  output logic                      done_o,
  output logic                      ok_o,
  output logic [gsa_pkg::IDX_W-1:0] out_index_o,
  output logic [gsa_pkg::GEN_W-1:0] out_generation_o,
  output logic [gsa_pkg::IDX_W-1:0] live_count_o,
  output logic [gsa_pkg::IDX_W-1:0] opened_slots_o
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int DW = 1 + gsa_pkg::GEN_W + $clog2(MAX_SLOTS + 1);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  gsa_core #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .handle_index_i     (handle_index_i),
    .handle_generation_i(handle_generation_i),
    .slot_position_i    (slot_position_i),
    .definition_ok_i    (definition_ok_i),
    .done_o             (done_o),
    .ok_o               (ok_o),
    .out_index_o        (out_index_o),
    .out_generation_o   (out_generation_o),
    .live_count_o       (live_count_o),
    .opened_slots_o     (opened_slots_o),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .ram_re_o           (ram_re),
    .ram_raddr_o        (ram_raddr),
    .ram_rdata_i        (ram_rdata)
  );

  gsa_slot_ram #(
    .DEPTH(MAX_SLOTS),
    .DW   (DW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
